### rtl/i2c_tlm_pkg.sv
// Shared constants, codes and types for the line-framed I2C target mailbox.
package i2c_tlm_pkg;

    localparam int RX_BUFFERS      = 4;
    localparam int RX_BUFFER_BYTES = 128;
    localparam int TX_MTU          = 256;
    localparam int TX_BUFFERS      = 2;

    localparam int RX_TOTAL  = RX_BUFFERS * RX_BUFFER_BYTES;
    localparam int TX_TOTAL  = TX_MTU * TX_BUFFERS;
    localparam int RX_IDX_W  = (RX_BUFFERS > 1) ? $clog2(RX_BUFFERS) : 1;
    localparam int RX_ADDR_W = $clog2(RX_TOTAL);
    localparam int RX_LEN_W  = $clog2(RX_BUFFER_BYTES + 1);
    localparam int TX_PTR_W  = $clog2(TX_TOTAL);
    localparam int TX_CNT_W  = $clog2(TX_TOTAL + 1);

    localparam logic [2:0] ACT_BUS_WRITE   = 3'd0;
    localparam logic [2:0] ACT_BUS_READ    = 3'd1;
    localparam logic [2:0] ACT_TX_BYTE     = 3'd2;
    localparam logic [2:0] ACT_FREE        = 3'd3;
    localparam logic [2:0] ACT_READ_STORED = 3'd4;

    localparam logic       REG_READ_ADDR = 1'b0;

    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       message_last;
        logic [1:0] buffer_index;
        logic [6:0] byte_offset;
    } item_t;

    typedef struct packed {
        logic       frame_valid;
        logic [1:0] frame_buffer;
        logic [7:0] frame_length;
        logic       dropping;
        logic       rd_mem;
    } rx_res_t;

    typedef struct packed {
        logic read_ok;
        logic rd_mem;
        logic rd_empty;
        logic tx_message_short;
    } tx_res_t;

endpackage

### rtl/i2c_tlm_ram.sv
// Generic simple dual-port RAM with registered read.
module i2c_tlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/i2c_tlm_rx.sv
// Receive side: buffer pool control, line framing and receive byte store.
module i2c_tlm_rx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  i2c_tlm_pkg::item_t item,
    input  logic [7:0]         read_register_address,
    output i2c_tlm_pkg::rx_res_t res,
    output logic [7:0]         rdata
);
    import i2c_tlm_pkg::*;

    logic [RX_LEN_W-1:0]   len_reg  [RX_BUFFERS];
    logic [RX_LEN_W-1:0]   len_next [RX_BUFFERS];
    logic [RX_BUFFERS-1:0] busy_reg;
    logic [RX_BUFFERS-1:0] busy_next;
    logic                  have_reg;
    logic                  have_next;
    logic [RX_IDX_W-1:0]   cur_reg;
    logic [RX_IDX_W-1:0]   cur_next;
    logic                  ign_reg;
    logic                  ign_next;

    logic                  wen_c;
    logic                  ren_c;
    logic [RX_ADDR_W-1:0]  waddr;
    logic [RX_ADDR_W-1:0]  raddr;

    always_comb
    begin
        logic                found;
        logic [RX_IDX_W-1:0] free_idx;
        logic [RX_LEN_W-1:0] len;
        logic [RX_LEN_W-1:0] new_len;
        logic [RX_IDX_W-1:0] sel_idx;

        found    = 1'b0;
        free_idx = '0;
        for (int i = RX_BUFFERS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                found    = 1'b1;
                free_idx = RX_IDX_W'(i);
            end
        end

        len_next  = len_reg;
        busy_next = busy_reg;
        have_next = have_reg;
        cur_next  = cur_reg;
        ign_next  = ign_reg;
        wen_c     = 1'b0;
        ren_c     = 1'b0;
        waddr     = '0;
        raddr     = '0;
        res       = '0;
        len       = len_reg[cur_reg];
        new_len   = len;
        sel_idx   = RX_IDX_W'(item.buffer_index);

        case (item.action)
            ACT_BUS_WRITE:
            begin
                if (!ign_reg && !have_reg)
                begin
                    if (found)
                    begin
                        busy_next[free_idx] = 1'b1;
                        len_next[free_idx]  = '0;
                        cur_next            = free_idx;
                        have_next           = 1'b1;
                        len                 = '0;
                        new_len             = '0;
                    end
                    else
                    begin
                        ign_next = 1'b1;
                    end
                end
                if (!ign_next && have_next)
                begin
                    if (len >= RX_LEN_W'(RX_BUFFER_BYTES))
                    begin
                        busy_next[cur_next] = 1'b0;
                        have_next           = 1'b0;
                        ign_next            = 1'b1;
                    end
                    else if (item.data_byte != read_register_address)
                    begin
                        wen_c              = 1'b1;
                        waddr              = RX_ADDR_W'(cur_next * RX_BUFFER_BYTES)
                                           + RX_ADDR_W'(len);
                        new_len            = len + RX_LEN_W'(1);
                        len_next[cur_next] = new_len;
                    end
                end
                if (item.data_byte == NEWLINE)
                begin
                    if (ign_next)
                    begin
                        ign_next = 1'b0;
                    end
                    else if (have_next)
                    begin
                        have_next        = 1'b0;
                        res.frame_valid  = 1'b1;
                        res.frame_buffer = 2'(cur_next);
                        res.frame_length = 8'(new_len);
                    end
                end
            end
            ACT_FREE:
            begin
                if (32'(item.buffer_index) < RX_BUFFERS)
                begin
                    busy_next[sel_idx] = 1'b0;
                    if (have_reg && cur_reg == sel_idx)
                    begin
                        have_next = 1'b0;
                    end
                end
            end
            ACT_READ_STORED:
            begin
                if (32'(item.buffer_index) < RX_BUFFERS
                    && 32'(item.byte_offset) < RX_BUFFER_BYTES)
                begin
                    ren_c      = 1'b1;
                    raddr      = RX_ADDR_W'(sel_idx * RX_BUFFER_BYTES)
                               + RX_ADDR_W'(item.byte_offset);
                    res.rd_mem = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        res.dropping = ign_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RX_BUFFERS; i++)
            begin
                len_reg[i] <= '0;
            end
            busy_reg <= '0;
            have_reg <= 1'b0;
            cur_reg  <= '0;
            ign_reg  <= 1'b0;
        end
        else if (accept)
        begin
            len_reg  <= len_next;
            busy_reg <= busy_next;
            have_reg <= have_next;
            cur_reg  <= cur_next;
            ign_reg  <= ign_next;
        end
    end

    i2c_tlm_ram #(
        .WIDTH (8),
        .DEPTH (RX_TOTAL)
    ) u_rx_mem (
        .clk   (clk),
        .wen   (accept && wen_c),
        .waddr (waddr),
        .wdata (item.data_byte),
        .ren   (accept && ren_c),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

### rtl/i2c_tlm_tx.sv
// Transmit side: byte ring control and ring store.
module i2c_tlm_tx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  i2c_tlm_pkg::item_t item,
    output i2c_tlm_pkg::tx_res_t res,
    output logic [7:0]         rdata
);
    import i2c_tlm_pkg::*;

    logic [TX_PTR_W-1:0] rd_ptr_reg;
    logic [TX_PTR_W-1:0] rd_ptr_next;
    logic [TX_PTR_W-1:0] wr_ptr_reg;
    logic [TX_PTR_W-1:0] wr_ptr_next;
    logic [TX_CNT_W-1:0] cnt_reg;
    logic [TX_CNT_W-1:0] cnt_next;
    logic                drop_reg;
    logic                drop_next;
    logic                wen_c;
    logic                ren_c;

    function automatic logic [TX_PTR_W-1:0] ring_next(input logic [TX_PTR_W-1:0] p);
        return (p == TX_PTR_W'(TX_TOTAL - 1)) ? '0 : p + TX_PTR_W'(1);
    endfunction

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        wen_c       = 1'b0;
        ren_c       = 1'b0;
        res         = '0;

        case (item.action)
            ACT_BUS_READ:
            begin
                if (cnt_reg != '0)
                begin
                    ren_c       = 1'b1;
                    rd_ptr_next = ring_next(rd_ptr_reg);
                    cnt_next    = cnt_reg - TX_CNT_W'(1);
                    res.read_ok = 1'b1;
                    res.rd_mem  = 1'b1;
                end
                else
                begin
                    res.rd_empty = 1'b1;
                end
            end
            ACT_TX_BYTE:
            begin
                if (cnt_reg < TX_CNT_W'(TX_TOTAL))
                begin
                    wen_c       = 1'b1;
                    wr_ptr_next = ring_next(wr_ptr_reg);
                    cnt_next    = cnt_reg + TX_CNT_W'(1);
                end
                else
                begin
                    drop_next = 1'b1;
                end
                if (item.message_last)
                begin
                    res.tx_message_short = drop_next;
                    drop_next            = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
        end
        else if (accept)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
        end
    end

    i2c_tlm_ram #(
        .WIDTH (8),
        .DEPTH (TX_TOTAL)
    ) u_tx_ring (
        .clk   (clk),
        .wen   (accept && wen_c),
        .waddr (wr_ptr_reg),
        .wdata (item.data_byte),
        .ren   (accept && ren_c),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

endmodule

### rtl/i2c_target_line_mailbox.sv
// Top level of the line-framed I2C target mailbox.
// Input channel (in_valid/in_stall) carries one word per event: a bus write
// byte, a bus read request, a software transmit byte, a buffer free, or a
// stored byte read. Every accepted word yields exactly one result word on the
// output channel (out_valid/out_stall), in order.
// Pipeline: the middle stage performs the receive-store or ring access (one
// port each) and registers the word's result; the output stage registers the
// result word. Throughput: one word per cycle while out_stall is low, set by the
// single access per word to each memory.
// When out_stall holds a result, one more word may enter and wait in the
// middle stage; after that in_stall rises until the output drains.
// Reset (rst_n low, asynchronous) frees all receive buffers, clears dropping,
// empties the transmit ring and sets read_register_address to zero. The
// memories are not cleared; no clearing pass is needed and words are taken
// from the first cycle after reset.
// The APB port holds read_register_address at byte address 0; write it only
// while the block is idle.
module i2c_target_line_mailbox (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        message_last,
    input  logic [1:0]  buffer_index,
    input  logic [6:0]  byte_offset,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_valid,
    output logic [1:0]  frame_buffer,
    output logic [7:0]  frame_length,
    output logic [7:0]  read_byte,
    output logic        read_ok,
    output logic        dropping,
    output logic        tx_message_short
);
    import i2c_tlm_pkg::*;

    logic [7:0] rra_val_reg;
    item_t      item;
    logic       accept;
    logic       advance;
    rx_res_t    rx_res;
    tx_res_t    tx_res;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;
    logic       s1_valid_reg;
    rx_res_t    s1_rx_reg;
    tx_res_t    s1_tx_reg;
    logic [7:0] byte_sel;

    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rra_val_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_READ_ADDR)
        begin
            rra_val_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_READ_ADDR) ? {24'h0, rra_val_reg} : 32'h0;

    assign item = {action, data_byte, message_last, buffer_index, byte_offset};

    assign advance  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    i2c_tlm_rx u_rx (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .accept                (accept),
        .item                  (item),
        .read_register_address (rra_val_reg),
        .res                   (rx_res),
        .rdata                 (rx_rdata)
    );

    i2c_tlm_tx u_tx (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .res    (tx_res),
        .rdata  (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rx_reg <= rx_res;
            s1_tx_reg <= tx_res;
        end
    end

    always_comb
    begin
        if (s1_rx_reg.rd_mem)
        begin
            byte_sel = rx_rdata;
        end
        else if (s1_tx_reg.rd_mem)
        begin
            byte_sel = tx_rdata;
        end
        else if (s1_tx_reg.rd_empty)
        begin
            byte_sel = EMPTY_BYTE;
        end
        else
        begin
            byte_sel = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            frame_valid      <= s1_rx_reg.frame_valid;
            frame_buffer     <= s1_rx_reg.frame_buffer;
            frame_length     <= s1_rx_reg.frame_length;
            dropping         <= s1_rx_reg.dropping;
            read_byte        <= byte_sel;
            read_ok          <= s1_tx_reg.read_ok;
            tx_message_short <= s1_tx_reg.tx_message_short;
        end
    end

endmodule
